### rtl/core/uue_pkg.sv
// Shared types and constants for the UTF-32 to UTF-8/UTF-16 encoder.
`default_nettype none

package uue_pkg;

   localparam int CP_W        = 21;
   localparam int UNIT_W      = 16;
   localparam int MAX_UNITS   = 4;
   localparam int IDX_W       = 2;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Range limits for classification
   localparam logic [CP_W-1:0] CP_LIM_ONE   = 21'h00_0080;
   localparam logic [CP_W-1:0] CP_LIM_TWO   = 21'h00_0800;
   localparam logic [CP_W-1:0] CP_LIM_BMP   = 21'h01_0000;
   localparam logic [CP_W-1:0] CP_MAX       = 21'h10_FFFF;
   localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00_D800;
   localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00_DFFF;

   // UTF-8 byte prefixes
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // UTF-16 surrogate bases
   localparam logic [UNIT_W-1:0] UTF16_HIGH_BASE = 16'hD800;
   localparam logic [UNIT_W-1:0] UTF16_LOW_BASE  = 16'hDC00;

   typedef enum logic {
      FORM_UTF8  = 1'b0,
      FORM_UTF16 = 1'b1
   } form_type;

   // One classified code point, ready for the unit sequencer
   typedef struct packed {
      logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
      logic [IDX_W-1:0]                 last_idx;
      logic                             invalid;
      logic                             string_end;
   } entry_type;

endpackage

`default_nettype wire

### rtl/core/uue_channels_if.sv
// Handshake channel interfaces for the encoder: input, result and config.
`default_nettype none

interface uue_req_if;
   logic                       valid;
   logic                       ready;
   logic [uue_pkg::CP_W-1:0]   code_point;
   logic                       last_in_string;

   modport source (output valid, output code_point, output last_in_string, input ready);
   modport sink   (input valid, input code_point, input last_in_string, output ready);
endinterface

interface uue_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [uue_pkg::UNIT_W-1:0] code_unit;
   logic                       last_unit;
   logic                       string_end;
   logic                       invalid;

   modport source (output valid, output code_unit, output last_unit, output string_end,
                   output invalid, input ready);
   modport sink   (input valid, input code_unit, input last_unit, input string_end,
                   input invalid, output ready);
endinterface

interface uue_csr_if;
   logic valid;
   logic ready;
   logic output_form;

   modport source (output valid, output output_form, input ready);
   modport sink   (input valid, input output_form, output ready);
endinterface

`default_nettype wire

### rtl/core/utf32_to_utf8_utf16_encoder_unit.sv
// Top level of the UTF-32 to UTF-8/UTF-16 encoder.
`default_nettype none

// Flow: an accepted code point is written into the queue, and each of its units then
//   passes through the result register before it is presented.
// Rate: one unit per cycle from the back end sequencer while the receiver is ready; a
//   code point gives 1 to 4 units, 4 for a four-byte UTF-8 sequence.
// Reset: clears the queue, the unit counter, the result valid and sets UTF-8 output.
module utf32_to_utf8_utf16_encoder_unit #(
   parameter int QUEUE_DEPTH = uue_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   uue_req_if.sink    req_ch,
   uue_rsp_if.source  rsp_ch,
   uue_csr_if.sink    csr_ch
);

   // Front end classifies each code point combinationally into a full unit list.
   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   uue_pkg::entry_type  push_entry;
   uue_pkg::entry_type  head_entry;

   uue_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue: input stays open while a long UTF-8 run drains.
   uue_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // Back end emits one unit word per cycle through a registered output while the receiver is ready.
   uue_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head_entry),
      .empty  (queue_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

### rtl/core/uue_front.sv
// Front end: form register, input word classification and unit build.
`default_nettype none

module uue_front (
   input  logic                clock,
   input  logic                reset,
   uue_req_if.sink             req_ch,
   uue_csr_if.sink             csr_ch,
   input  logic                queue_full,
   output logic                push,
   output uue_pkg::entry_type  push_entry
);

   uue_pkg::form_type             output_form_ff;
   uue_pkg::form_type             output_form_in;
   logic [uue_pkg::CP_W-1:0]      cp;
   logic [uue_pkg::CP_W-1:0]      supp;
   logic                          bad;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      output_form_in = output_form_ff;
      if (csr_ch.valid) begin
         output_form_in = uue_pkg::form_type'(csr_ch.output_form);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_form_ff <= uue_pkg::FORM_UTF8;
      end else begin
         output_form_ff <= output_form_in;
      end
   end

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   assign cp   = req_ch.code_point;
   assign supp = cp - uue_pkg::CP_LIM_BMP;
   assign bad  = (cp >= uue_pkg::CP_SURR_LO && cp <= uue_pkg::CP_SURR_HI)
              || (cp > uue_pkg::CP_MAX);

   always_comb begin
      push_entry            = '0;
      push_entry.string_end = req_ch.last_in_string;
      priority if (bad) begin
         push_entry.invalid = 1'b1;
      end else if (output_form_ff == uue_pkg::FORM_UTF8) begin
         priority if (cp < uue_pkg::CP_LIM_ONE) begin
            push_entry.units[0] = cp[uue_pkg::UNIT_W-1:0];
         end else if (cp < uue_pkg::CP_LIM_TWO) begin
            push_entry.units[0] = {8'h00, uue_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}};
            push_entry.units[1] = {8'h00, uue_pkg::UTF8_CONT  | {2'b00, cp[5:0]}};
            push_entry.last_idx = 2'd1;
         end else if (cp < uue_pkg::CP_LIM_BMP) begin
            push_entry.units[0] = {8'h00, uue_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]}};
            push_entry.units[1] = {8'h00, uue_pkg::UTF8_CONT  | {2'b00, cp[11:6]}};
            push_entry.units[2] = {8'h00, uue_pkg::UTF8_CONT  | {2'b00, cp[5:0]}};
            push_entry.last_idx = 2'd2;
         end else begin
            push_entry.units[0] = {8'h00, uue_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]}};
            push_entry.units[1] = {8'h00, uue_pkg::UTF8_CONT  | {2'b00, cp[17:12]}};
            push_entry.units[2] = {8'h00, uue_pkg::UTF8_CONT  | {2'b00, cp[11:6]}};
            push_entry.units[3] = {8'h00, uue_pkg::UTF8_CONT  | {2'b00, cp[5:0]}};
            push_entry.last_idx = 2'd3;
         end
      end else begin
         if (cp < uue_pkg::CP_LIM_BMP) begin
            push_entry.units[0] = cp[uue_pkg::UNIT_W-1:0];
         end else begin
            // surrogate pair from the 20-bit offset above the BMP
            push_entry.units[0] = uue_pkg::UTF16_HIGH_BASE | {6'b000000, supp[19:10]};
            push_entry.units[1] = uue_pkg::UTF16_LOW_BASE  | {6'b000000, supp[9:0]};
            push_entry.last_idx = 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/uue_queue.sv
// Short FIFO of classified code points between front and back end.
`default_nettype none

module uue_queue #(
   parameter int DEPTH = uue_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uue_pkg::entry_type  push_entry,
   input  logic                pop,
   output uue_pkg::entry_type  head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   uue_pkg::entry_type  slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff,  count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_DEPTH);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### rtl/core/uue_back.sv
// Back end: walks the units of the head entry into the result register.
`default_nettype none

module uue_back (
   input  logic                clock,
   input  logic                reset,
   input  uue_pkg::entry_type  head,
   input  logic                empty,
   output logic                pop,
   uue_rsp_if.source           rsp_ch
);

   logic [uue_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [uue_pkg::UNIT_W-1:0] code_unit_ff;
   logic                       last_unit_ff;
   logic                       string_end_ff;
   logic                       invalid_ff;
   logic                       load;
   logic                       take;
   logic                       unit_last;

   assign load      = !rsp_valid_ff || rsp_ch.ready;
   assign take      = load && !empty;
   assign unit_last = (idx_ff == head.last_idx);
   assign pop       = take && unit_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = !empty;
      end
      if (take) begin
         idx_in = unit_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         code_unit_ff  <= head.units[idx_ff];
         last_unit_ff  <= unit_last;
         string_end_ff <= unit_last && head.string_end;
         invalid_ff    <= head.invalid;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.code_unit  = code_unit_ff;
   assign rsp_ch.last_unit  = last_unit_ff;
   assign rsp_ch.string_end = string_end_ff;
   assign rsp_ch.invalid    = invalid_ff;

   // never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop while queue empty");

   // unit index stays within the head entry's run
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (idx_ff <= head.last_idx))
      else $error("unit index past last unit");

   // an invalid word is a lone zero unit closing its code point
   a_invalid_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && invalid_ff) |-> (last_unit_ff && code_unit_ff == '0))
      else $error("malformed invalid word");

   // string end only marks a final unit
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && string_end_ff) |-> last_unit_ff)
      else $error("string end on non-final unit");

   // a word is emitted the cycle after a unit was taken
   a_take_emits: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("taken unit not presented");

endmodule

`default_nettype wire

### tb/tb_utf32_to_utf8_utf16_encoder_unit.sv
// Testbench for the UTF-32 to UTF-8/UTF-16 encoder: directed and random code points, both forms.
`timescale 1ns / 100ps

module tb_utf32_to_utf8_utf16_encoder_unit;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all before giving up
   localparam int DRAIN_CYCLES = 8;     // settle time after the last unit arrives
   localparam int PHASE_WORDS  = 60;    // random words per register setting

   // One code unit as it should leave the result channel
   typedef struct {
      logic [uue_pkg::UNIT_W-1:0] code_unit;
      logic                       last_unit;
      logic                       string_end;
      logic                       invalid;
   } unit_word_type;

   // Receiver stall patterns, picked anew at random as the run goes on
   typedef enum logic [1:0] {
      DRAIN_FULL,     // never stalls
      DRAIN_COIN,     // 50/50 each cycle
      DRAIN_PULSE,    // ready three fifths of the time, in a repeating pattern
      DRAIN_TRICKLE   // ready one cycle in four on average
   } drain_mode_type;

   // Expected code units in arrival order, plus the output form the encoder should be using.
   class unit_scoreboard;
      uue_pkg::form_type form;
      unit_word_type     expected_units[$];
      int                errors;

      function new();
         form   = uue_pkg::FORM_UTF8;
         errors = 0;
      endfunction

      function void set_form(logic f);
         form = uue_pkg::form_type'(f);
      endfunction

      function int pending();
         return expected_units.size();
      endfunction

      // Encode one accepted code point and queue the units it should produce.
      function void note_code_point(logic [uue_pkg::CP_W-1:0] cp, logic ends_string);
         logic [uue_pkg::UNIT_W-1:0] units[uue_pkg::MAX_UNITS];
         logic [uue_pkg::CP_W-1:0]   offset;
         unit_word_type              w;
         int                         n;

         // Surrogates and values past the Unicode range collapse to one flagged unit
         if ((cp >= uue_pkg::CP_SURR_LO && cp <= uue_pkg::CP_SURR_HI) ||
             cp > uue_pkg::CP_MAX) begin
            w.code_unit  = '0;
            w.last_unit  = 1'b1;
            w.string_end = ends_string;
            w.invalid    = 1'b1;
            expected_units.push_back(w);
            return;
         end

         if (form == uue_pkg::FORM_UTF8) begin
            if (cp < uue_pkg::CP_LIM_ONE) begin
               units[0] = cp[uue_pkg::UNIT_W-1:0];
               n = 1;
            end else if (cp < uue_pkg::CP_LIM_TWO) begin
               units[0] = {8'h00, uue_pkg::UTF8_LEAD2 | 8'(cp >> 6)};
               units[1] = {8'h00, uue_pkg::UTF8_CONT | {2'b00, cp[5:0]}};
               n = 2;
            end else if (cp < uue_pkg::CP_LIM_BMP) begin
               units[0] = {8'h00, uue_pkg::UTF8_LEAD3 | 8'(cp >> 12)};
               units[1] = {8'h00, uue_pkg::UTF8_CONT | {2'b00, cp[11:6]}};
               units[2] = {8'h00, uue_pkg::UTF8_CONT | {2'b00, cp[5:0]}};
               n = 3;
            end else begin
               units[0] = {8'h00, uue_pkg::UTF8_LEAD4 | 8'(cp >> 18)};
               units[1] = {8'h00, uue_pkg::UTF8_CONT | {2'b00, cp[17:12]}};
               units[2] = {8'h00, uue_pkg::UTF8_CONT | {2'b00, cp[11:6]}};
               units[3] = {8'h00, uue_pkg::UTF8_CONT | {2'b00, cp[5:0]}};
               n = 4;
            end
         end else begin
            if (cp < uue_pkg::CP_LIM_BMP) begin
               units[0] = cp[uue_pkg::UNIT_W-1:0];
               n = 1;
            end else begin
               offset   = cp - uue_pkg::CP_LIM_BMP;
               units[0] = uue_pkg::UTF16_HIGH_BASE + {6'b0, offset[19:10]};
               units[1] = uue_pkg::UTF16_LOW_BASE + {6'b0, offset[9:0]};
               n = 2;
            end
         end

         for (int k = 0; k < n; k++) begin
            w.code_unit  = units[k];
            w.last_unit  = (k == n - 1);
            w.string_end = (k == n - 1) && ends_string;
            w.invalid    = 1'b0;
            expected_units.push_back(w);
         end
      endfunction

      // Compare one delivered unit against the oldest expectation.
      function void check_unit(logic [uue_pkg::UNIT_W-1:0] cu, logic lu, logic se, logic inv);
         unit_word_type w;

         if (expected_units.size() == 0) begin
            $error("unexpected code unit %h (last_unit %b string_end %b invalid %b)",
                   cu, lu, se, inv);
            errors++;
            return;
         end
         w = expected_units.pop_front();
         if (cu !== w.code_unit) begin
            $error("code_unit: expected %h, actual %h", w.code_unit, cu);
            errors++;
         end
         if (lu !== w.last_unit) begin
            $error("last_unit: expected %b, actual %b", w.last_unit, lu);
            errors++;
         end
         if (se !== w.string_end) begin
            $error("string_end: expected %b, actual %b", w.string_end, se);
            errors++;
         end
         if (inv !== w.invalid) begin
            $error("invalid: expected %b, actual %b", w.invalid, inv);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   uue_req_if req_bus ();
   uue_rsp_if rsp_bus ();
   uue_csr_if csr_bus ();

   utf32_to_utf8_utf16_encoder_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus.sink),
      .rsp_ch (rsp_bus.source),
      .csr_ch (csr_bus.sink)
   );

   unit_scoreboard sb = new();

   int             burst_left;   // words left in the sender's current burst
   int             idle_cycles;  // watchdog: consecutive cycles without any handshake
   int             drain_cycle;
   drain_mode_type drain_mode;

   // Everything the block sees is known from time zero.
   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.code_point     = '0;
      req_bus.last_in_string = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.output_form    = uue_pkg::FORM_UTF8;
      rsp_bus.ready          = 1'b0;
      burst_left             = 0;
      idle_cycles            = 0;
      drain_cycle            = 0;
      drain_mode             = DRAIN_FULL;
   end

   always #4 clock = ~clock;

   // Receiver: ready follows a stall pattern picked anew at random as the run goes on, so stalls
   // land on every unit position of a code point, with stretches of no stalls too.
   always @(negedge clock) begin
      drain_cycle <= drain_cycle + 1;
      if (drain_cycle % 80 == 0)
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
      case (drain_mode)
         DRAIN_FULL:    rsp_bus.ready <= 1'b1;
         DRAIN_COIN:    rsp_bus.ready <= 1'($urandom_range(0, 1));
         DRAIN_PULSE:   rsp_bus.ready <= (drain_cycle % 5) < 3;
         DRAIN_TRICKLE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:       rsp_bus.ready <= 1'b1;
      endcase
   end

   // Result monitor: every delivered unit goes straight to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_unit(rsp_bus.code_unit, rsp_bus.last_unit, rsp_bus.string_end,
                       rsp_bus.invalid);
   end

   // Watchdog: a hung handshake on every channel at once ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Present one code point and hold it until taken. Valid stays high across a
   // burst; when the burst runs out the sender drops valid for a random pause.
   task automatic send_code_point(logic [uue_pkg::CP_W-1:0] cp, logic ends_string);
      if (burst_left == 0)
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      @(negedge clock);
      req_bus.valid          <= 1'b1;
      req_bus.code_point     <= cp;
      req_bus.last_in_string <= ends_string;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_code_point(cp, ends_string);
      burst_left--;
      if (burst_left == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Drop valid so a held word is not taken twice.
   task automatic release_input();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
   endtask

   // Wait for every queued unit, then switch the output form.
   task automatic write_output_form(uue_pkg::form_type f);
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.output_form <= f;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_form(f);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Random code point, weighted toward each encoding length, with a share of
   // surrogates, out-of-range values and fully random 21-bit values.
   function automatic logic [uue_pkg::CP_W-1:0] pick_code_point();
      int          pick;
      int unsigned raw;

      pick = $urandom_range(0, 99);
      if (pick < 20)      raw = $urandom_range(0, 'h7F);
      else if (pick < 35) raw = $urandom_range('h80, 'h7FF);
      else if (pick < 55) raw = $urandom_range('h800, 'hFFFF);
      else if (pick < 75) raw = $urandom_range('h10000, 'h10FFFF);
      else if (pick < 85) raw = $urandom_range('hD800, 'hDFFF);
      else if (pick < 92) raw = $urandom_range('h110000, 'h1FFFFF);
      else                raw = $urandom_range(0, 'h1FFFFF);
      return raw[uue_pkg::CP_W-1:0];
   endfunction

   logic [uue_pkg::CP_W-1:0] corner_points[12] = '{
      21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D800,
      21'h00DFFF, 21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF
   };

   initial begin
      int sent;
      int len;
      logic ends_string;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every length boundary, both surrogate edges and the range
      // limits, first as UTF-8 then as UTF-16. The zero code point goes
      // through both with and without the string-end flag.
      write_output_form(uue_pkg::FORM_UTF8);
      foreach (corner_points[i])
         send_code_point(corner_points[i], 1'(i % 2));
      release_input();
      write_output_form(uue_pkg::FORM_UTF16);
      foreach (corner_points[i])
         send_code_point(corner_points[i], 1'((i + 1) % 2));
      release_input();

      // Random: strings of one to ten code points, the last one flagged as
      // ending the string; now and then the flag is scrambled as noise.
      for (int phase = 0; phase < 6; phase++) begin
         write_output_form((phase % 2 == 0) ? uue_pkg::FORM_UTF8 : uue_pkg::FORM_UTF16);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len && sent < PHASE_WORDS; i++) begin
               ends_string = (i == len - 1);
               if ($urandom_range(0, 9) == 0)
                  ends_string = 1'($urandom_range(0, 1));
               send_code_point(pick_code_point(), ends_string);
               sent++;
            end
         end
         release_input();
      end

      // Drain, then give the block a settle time to show any stray unit.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
